FILE: hdl/llda_pkg.sv
`timescale 1ns / 1ps

package llda_pkg;

	// field widths fixed by the item format
	localparam int ACTION_W  = 3;
	localparam int ID_W      = 3;
	localparam int OUT_CNT_W = 16;
	localparam int STATUS_W  = 2;
	localparam int DEVCNT_W  = 4;

	// internal device number: wide enough for any device the register can enable
	localparam int DEV_W    = DEVCNT_W;
	localparam int MAX_LIVE = (1 << DEVCNT_W) - 1;

	localparam int MAX_DEVICES_DEF = 8;
	localparam int COUNT_WIDTH_DEF = 16;

	localparam logic [DEVCNT_W-1:0] DEVCNT_RST = 4'd8;

	localparam logic [ACTION_W-1:0] ACT_ACQ_AUTO  = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_ACQ_NAMED = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_REL_NAMED = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_REL_CUR   = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_QUERY     = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_AT_ZERO   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_SATURATED = 2'd3;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [ID_W-1:0]     device_id;
	} llda_req_t;

	typedef struct packed {
		logic [ID_W-1:0]      chosen_device;
		logic [OUT_CNT_W-1:0] use_count;
		logic [STATUS_W-1:0]  status;
	} llda_rsp_t;

	typedef struct packed {
		logic load;
		logic scan_step;
		logic commit;
	} llda_cmd_t;

	typedef struct packed {
		logic auto_req;
		logic scan_done;
		logic out_free;
	} llda_sts_t;

endpackage

FILE: hdl/llda_ctrl.sv
`timescale 1ns / 1ps

module llda_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  llda_pkg::llda_sts_t sts,
	output llda_pkg::llda_cmd_t cmd
);
	import llda_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_EXEC = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d       = state_q;
		cmd.load      = 1'b0;
		cmd.scan_step = 1'b0;
		cmd.commit    = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = sts.auto_req ? S_SCAN : S_EXEC;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				// wait for room in the result register
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign req_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: hdl/llda_dp.sv
`timescale 1ns / 1ps

module llda_dp #(
	parameter int MAX_DEVICES = llda_pkg::MAX_DEVICES_DEF,
	parameter int COUNT_WIDTH = llda_pkg::COUNT_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  llda_pkg::llda_req_t               req,
	input  logic                              cfg_we,
	input  logic [llda_pkg::DEVCNT_W-1:0]     cfg_wdata,
	input  llda_pkg::llda_cmd_t               cmd,
	output llda_pkg::llda_sts_t               sts,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output llda_pkg::llda_rsp_t               rsp
);
	import llda_pkg::*;

	// only devices below the largest register value can ever be reached
	localparam int NUM_SLOTS = (MAX_DEVICES < MAX_LIVE) ? MAX_DEVICES : MAX_LIVE;
	localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	logic [COUNT_WIDTH-1:0] cnt_q [NUM_SLOTS];
	logic [DEVCNT_W-1:0]    devcnt_q;
	logic [ID_W-1:0]        cur_q;
	logic [ACTION_W-1:0]    action_q;
	logic [DEV_W-1:0]       dev_q;
	logic [DEV_W-1:0]       idx_q;
	logic [DEV_W-1:0]       best_q;
	logic [COUNT_WIDTH-1:0] best_cnt_q;
	logic                   rsp_valid_q;
	llda_rsp_t              rsp_q;

	logic [DEVCNT_W-1:0]    live;
	logic [DEV_W-1:0]       rd_addr;
	logic [COUNT_WIDTH-1:0] rd_cnt;
	logic                   rd_zero;
	logic                   better;
	logic                   scan_last;
	logic                   dev_ok;
	logic                   wr_en;
	logic [COUNT_WIDTH-1:0] wr_cnt;
	logic                   cur_en;
	logic [STATUS_W-1:0]    ex_status;
	logic [COUNT_WIDTH-1:0] ex_cnt;
	logic [OUT_CNT_W-1:0]   ex_cnt_out;

	assign live = (32'(devcnt_q) < MAX_DEVICES) ? devcnt_q : DEVCNT_W'(MAX_DEVICES);

	// single read port, shared by the scan and the update
	assign rd_addr = cmd.scan_step ? idx_q : dev_q;
	assign rd_cnt  = (32'(rd_addr) < NUM_SLOTS) ? cnt_q[rd_addr[SLOT_W-1:0]] : '0;
	assign rd_zero = (rd_cnt == '0);

	assign better    = (idx_q == '0) || (rd_cnt < best_cnt_q);
	assign scan_last = (live == '0) || rd_zero || (idx_q == live - 1'b1);

	assign sts.auto_req  = (req.action == ACT_ACQ_AUTO);
	assign sts.scan_done = scan_last;
	assign sts.out_free  = !rsp_valid_q || !rsp_stall;

	assign dev_ok = (dev_q < live);

	always_comb begin
		wr_en     = 1'b0;
		wr_cnt    = rd_cnt;
		cur_en    = 1'b0;
		ex_status = ST_OK;
		case (action_q)
			ACT_ACQ_AUTO, ACT_ACQ_NAMED: begin
				if (!dev_ok) begin
					ex_status = ST_INVALID;
				end else begin
					cur_en = 1'b1;
					if (rd_cnt == '1) begin
						ex_status = ST_SATURATED;
					end else begin
						wr_en  = 1'b1;
						wr_cnt = rd_cnt + 1'b1;
					end
				end
			end
			ACT_REL_NAMED, ACT_REL_CUR: begin
				if (!dev_ok) begin
					ex_status = ST_INVALID;
				end else if (rd_zero) begin
					ex_status = ST_AT_ZERO;
				end else begin
					wr_en  = 1'b1;
					wr_cnt = rd_cnt - 1'b1;
				end
			end
			default: begin
				ex_status = dev_ok ? ST_OK : ST_INVALID;
			end
		endcase
		ex_cnt = dev_ok ? wr_cnt : '0;
		// clamp wide counts to the result field
		if ((ex_cnt >> OUT_CNT_W) != '0) begin
			ex_cnt_out = '1;
		end else begin
			ex_cnt_out = OUT_CNT_W'(ex_cnt);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				cnt_q[i] <= '0;
			end
			devcnt_q    <= DEVCNT_RST;
			cur_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				devcnt_q <= cfg_wdata;
			end
			if (cmd.commit) begin
				if (wr_en) begin
					cnt_q[dev_q[SLOT_W-1:0]] <= wr_cnt;
				end
				if (cur_en) begin
					cur_q <= dev_q[ID_W-1:0];
				end
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= req.action;
			dev_q    <= (req.action == ACT_REL_CUR) ? DEV_W'(cur_q) : DEV_W'(req.device_id);
			idx_q    <= '0;
			best_q   <= '0;
		end
		if (cmd.scan_step) begin
			if (live == '0) begin
				dev_q <= '0;
			end else if (rd_zero) begin
				dev_q <= idx_q;
			end else begin
				if (better) begin
					best_q     <= idx_q;
					best_cnt_q <= rd_cnt;
				end
				if (scan_last) begin
					dev_q <= better ? idx_q : best_q;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
		if (cmd.commit) begin
			rsp_q.chosen_device <= dev_q[ID_W-1:0];
			rsp_q.use_count     <= ex_cnt_out;
			rsp_q.status        <= ex_status;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: hdl/least_loaded_device_allocator_unit.sv
`timescale 1ns / 1ps

// channel | valid     | stall     | payload    | transfer when
// --------+-----------+-----------+------------+-------------------------
// request | req_valid | req_stall | req        | req_valid && !req_stall
// result  | rsp_valid | rsp_stall | rsp        | rsp_valid && !rsp_stall
// config  | cfg_we    | -         | cfg_wdata  | cfg_we
//
// named acquire, releases and queries go from transfer through S_EXEC to the registered result
// acquire-least-used first runs a scan in S_SCAN that visits the counters (1 to live devices)
// the scan and the update share the one read port of the counter store
// the result sits in its own register, so a held result stalls only the final update
// arst_n clears all counters and the current device, and sets device_count to 8

module least_loaded_device_allocator_unit #(
	parameter int MAX_DEVICES = llda_pkg::MAX_DEVICES_DEF,
	parameter int COUNT_WIDTH = llda_pkg::COUNT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  llda_pkg::llda_req_t           req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output llda_pkg::llda_rsp_t           rsp,
	input  logic                          cfg_we,
	input  logic [llda_pkg::DEVCNT_W-1:0] cfg_wdata
);
	import llda_pkg::*;

	llda_cmd_t cmd;
	llda_sts_t sts;

	llda_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	llda_dp #(
		.MAX_DEVICES (MAX_DEVICES),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

FILE: hdl/llda_chk.sv
`timescale 1ns / 1ps

module llda_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_stall,
	input llda_pkg::llda_req_t req,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input llda_pkg::llda_rsp_t rsp
);
	import llda_pkg::*;

	// a held result keeps its value
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// one item at a time: an accepted request blocks the next cycle
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while busy");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_INVALID |-> rsp.use_count == '0)
		else $error("invalid device reported a count");

	a_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_AT_ZERO |-> rsp.use_count == '0)
		else $error("release at zero reported a count");

endmodule

bind least_loaded_device_allocator_unit llda_chk u_llda_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
